@@ hdl/btpc_pkg.sv @@
// Package: shared constants and types of the barometric compensation pipeline.
`default_nettype none
package btpc_pkg;

  localparam int unsigned NumStages = 80;
  localparam int unsigned SideFirst = 3;
  localparam int unsigned DivFirst  = 10;
  localparam int unsigned DivBits   = 64;
  localparam int unsigned CfgAddrW  = 8;
  localparam int unsigned CoeffW    = 48;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 96;

  typedef enum logic [CfgAddrW-1:0] {
    CfgTemp   = 8'd0,
    CfgPressA = 8'd1,
    CfgPressB = 8'd2,
    CfgPressC = 8'd3
  } cfg_reg_e;

  // Temperature results travelling beside the pressure datapath
  typedef struct packed {
    logic [31:0] fine;
    logic [24:0] centi;
  } side_t;

  // One stage of the restoring divider
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    logic        neg;
    logic        dz;
  } div_t;

endpackage
`default_nettype wire

@@ hdl/baro_temp_pressure_compensation.sv @@
// Pipeline: 80 register stages, from the input registers to the output register.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Pressure divider: 64 stages, one quotient bit per stage.
// Reset: rst_ni asynchronous, active low; clears valid bits and calibration registers.
// The user must write calibration registers only while the pipeline is empty; the block does not enforce this.
`default_nettype none
module baro_temp_pressure_compensation (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [19:0] temp_raw, [39:20] press_raw
  input  wire logic [btpc_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [31:0] fine_temp, [56:32] temp_centi, [88:57] press_q24_8, [95:89] zero
  output logic [btpc_pkg::OutDataW-1:0]      m_axis_tdata,
  // [0] div_zero
  output logic                               m_axis_tuser,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [btpc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [btpc_pkg::CoeffW-1:0]   cfg_data_i
);

  localparam int unsigned NSt = btpc_pkg::NumStages;
  localparam int unsigned DB  = btpc_pkg::DivBits;
  localparam int unsigned SF  = btpc_pkg::SideFirst;

  logic [btpc_pkg::CoeffW-1:0] temp_q, pa_q, pb_q, pc_q;
  logic [NSt-1:0] v_q;
  logic adv;

  // calibration fields
  logic [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = temp_q[15:0];
  assign t2 = temp_q[31:16];
  assign t3 = temp_q[47:32];
  assign p1 = pa_q[15:0];
  assign p2 = pa_q[31:16];
  assign p3 = pa_q[47:32];
  assign p4 = pb_q[15:0];
  assign p5 = pb_q[31:16];
  assign p6 = pb_q[47:32];
  assign p7 = pc_q[15:0];
  assign p8 = pc_q[31:16];
  assign p9 = pc_q[47:32];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      pa_q   <= '0;
      pb_q   <= '0;
      pc_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        btpc_pkg::CfgTemp:   temp_q <= cfg_data_i;
        btpc_pkg::CfgPressA: pa_q   <= cfg_data_i;
        btpc_pkg::CfgPressB: pb_q   <= cfg_data_i;
        btpc_pkg::CfgPressC: pc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // hold every stage while the output register is full and not taken
  assign adv           = !v_q[NSt-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v_q[NSt-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSt-2:0], s_axis_tvalid};
    end
  end

  // ---------------- temperature ----------------
  logic [19:0] traw, praw;
  logic signed [17:0] d1_d, d1_0_q;
  logic signed [16:0] d2_d, d2_0_q;
  logic signed [33:0] m1_d, m2_d, m1_1_q, m2_1_q;
  logic signed [21:0] sq;
  logic signed [22:0] tv1_2_q;
  logic signed [37:0] m3_d, m3_2_q;
  logic signed [23:0] tv2;
  logic signed [24:0] tfine;
  logic signed [31:0] tf32;
  logic signed [34:0] centi_full;
  logic [19:0] praw_q [0:7];
  btpc_pkg::side_t side_q [SF:NSt-1];

  assign traw = s_axis_tdata[19:0];
  assign praw = s_axis_tdata[39:20];
  assign d1_d = $signed({1'b0, traw[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d2_d = $signed({1'b0, traw[19:4]}) - $signed({1'b0, t1});
  assign m1_d = d1_0_q * t2;
  assign m2_d = d2_0_q * d2_0_q;
  assign sq   = m2_1_q[33:12];
  assign m3_d = sq * t3;
  assign tv2  = m3_2_q[37:14];
  assign tfine = {{2{tv1_2_q[22]}}, tv1_2_q} + {tv2[23], tv2};
  assign tf32  = {{7{tfine[24]}}, tfine};
  assign centi_full = $signed({{3{tf32[31]}}, tf32}) * 35'sd5 + 35'sd128;

  // ---------------- pressure front ----------------
  logic signed [32:0] a_d;
  logic signed [65:0] aa_full;
  logic signed [63:0] aa_4_q;
  logic signed [48:0] ap5_d, ap2_d, ap5_4_q, ap2_4_q, ap5_5_q, ap2_5_q;
  logic signed [63:0] b1_d, a3_d, b1_5_q, a3_5_q;
  logic [63:0] b_d, a2_d, x_d, b_6_q, x_6_q, b_7_q;
  logic [47:0] xl_d, xh_full, xl_7_q;
  logic [31:0] xh_7_q;
  logic [63:0] prod, den_d, n1_d, den_8_q, n1_8_q, num_d, num_9_q, den_9_q;
  logic [20:0] pr;

  assign a_d     = {side_q[SF+0].fine[31], side_q[SF+0].fine} - 33'sd128000;
  assign aa_full = a_d * a_d;
  assign ap5_d   = a_d * p5;
  assign ap2_d   = a_d * p2;
  assign b1_d    = aa_4_q * p6;
  assign a3_d    = aa_4_q * p3;
  assign b_d  = b1_5_q + {ap5_5_q[46:0], 17'b0} + {{13{p4[15]}}, p4, 35'b0};
  assign a2_d = {{8{a3_5_q[63]}}, a3_5_q[63:8]} + {{3{ap2_5_q[48]}}, ap2_5_q, 12'b0};
  assign x_d  = a2_d + 64'h0000_8000_0000_0000;
  assign xl_d    = x_6_q[31:0] * p1;
  assign xh_full = x_6_q[63:32] * p1;
  assign prod  = {16'b0, xl_7_q} + {xh_7_q, 32'b0};
  assign den_d = {{33{prod[63]}}, prod[63:33]};
  assign pr    = 21'd1048576 - {1'b0, praw_q[7]};
  assign n1_d  = {12'b0, pr, 31'b0} - b_7_q;
  assign num_d = n1_8_q * 64'd3125;

  // ---------------- divider ----------------
  btpc_pkg::div_t div_q [0:DB];
  btpc_pkg::div_t div_d [0:DB];
  logic [64:0] trial;

  always_comb begin
    div_d[0].neg = num_9_q[63] ^ den_9_q[63];
    div_d[0].dz  = (den_9_q == '0);
    div_d[0].num = num_9_q[63] ? (64'd0 - num_9_q) : num_9_q;
    div_d[0].den = den_9_q[63] ? (64'd0 - den_9_q) : den_9_q;
    div_d[0].rem = '0;
    div_d[0].quo = '0;
    trial = '0;
    for (int unsigned j = 0; j < DB; j++) begin
      trial          = {div_q[j].rem, div_q[j].num[63]};
      div_d[j+1]     = div_q[j];
      div_d[j+1].num = {div_q[j].num[62:0], 1'b0};
      if (trial >= {1'b0, div_q[j].den}) begin
        div_d[j+1].rem = 64'(trial - {1'b0, div_q[j].den});
        div_d[j+1].quo = {div_q[j].quo[62:0], 1'b1};
      end else begin
        div_d[j+1].rem = trial[63:0];
        div_d[j+1].quo = {div_q[j].quo[62:0], 1'b0};
      end
    end
  end

  // ---------------- pressure back ----------------
  logic signed [63:0] p_d, p_75_q, p_76_q, p_77_q, ps_d, ps_76_q;
  logic signed [63:0] m9_d, c2m_d, m9_76_q, c2m_76_q, c2m_77_q;
  logic [63:0] ll_d, lh_full, hl_full, ll_77_q;
  logic [31:0] lh_77_q, hl_77_q;
  logic [63:0] c1full, c1, c2, s_d, s_78_q, pf;
  logic [31:0] press_d, press_q;
  logic dz_75_q, dz_76_q, dz_77_q, dz_78_q, dz_q;

  assign p_d   = div_q[DB].neg ? (64'd0 - div_q[DB].quo) : div_q[DB].quo;
  assign ps_d  = {{13{p_75_q[63]}}, p_75_q[63:13]};
  assign m9_d  = ps_d * p9;
  assign c2m_d = p_75_q * p8;
  assign ll_d    = m9_76_q[31:0] * ps_76_q[31:0];
  assign lh_full = m9_76_q[31:0] * ps_76_q[63:32];
  assign hl_full = m9_76_q[63:32] * ps_76_q[31:0];
  assign c1full = ll_77_q + {32'(lh_77_q + hl_77_q), 32'b0};
  assign c1     = {{25{c1full[63]}}, c1full[63:25]};
  assign c2     = {{19{c2m_77_q[63]}}, c2m_77_q[63:19]};
  assign s_d    = p_77_q + c1 + c2;
  assign pf     = {{8{s_78_q[63]}}, s_78_q[63:8]} + {{44{p7[15]}}, p7, 4'b0};

  always_comb begin
    if (dz_78_q || pf[63]) begin
      press_d = '0;
    end else if (|pf[62:32]) begin
      press_d = '1;
    end else begin
      press_d = pf[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_0_q    <= d1_d;
      d2_0_q    <= d2_d;
      praw_q[0] <= praw;
      for (int unsigned k = 1; k < 8; k++) begin
        praw_q[k] <= praw_q[k-1];
      end
      m1_1_q  <= m1_d;
      m2_1_q  <= m2_d;
      tv1_2_q <= m1_1_q[33:11];
      m3_2_q  <= m3_d;
      side_q[SF].fine  <= tf32;
      side_q[SF].centi <= centi_full[32:8];
      for (int unsigned k = SF + 1; k < NSt; k++) begin
        side_q[k] <= side_q[k-1];
      end
      aa_4_q  <= aa_full[63:0];
      ap5_4_q <= ap5_d;
      ap2_4_q <= ap2_d;
      b1_5_q  <= b1_d;
      a3_5_q  <= a3_d;
      ap5_5_q <= ap5_4_q;
      ap2_5_q <= ap2_4_q;
      b_6_q   <= b_d;
      x_6_q   <= x_d;
      xl_7_q  <= xl_d;
      xh_7_q  <= xh_full[31:0];
      b_7_q   <= b_6_q;
      den_8_q <= den_d;
      n1_8_q  <= n1_d;
      num_9_q <= num_d;
      den_9_q <= den_8_q;
      for (int unsigned j = 0; j <= DB; j++) begin
        div_q[j] <= div_d[j];
      end
      p_75_q   <= p_d;
      dz_75_q  <= div_q[DB].dz;
      m9_76_q  <= m9_d;
      ps_76_q  <= ps_d;
      c2m_76_q <= c2m_d;
      p_76_q   <= p_75_q;
      dz_76_q  <= dz_75_q;
      ll_77_q  <= ll_d;
      lh_77_q  <= lh_full[31:0];
      hl_77_q  <= hl_full[31:0];
      c2m_77_q <= c2m_76_q;
      p_77_q   <= p_76_q;
      dz_77_q  <= dz_76_q;
      s_78_q   <= s_d;
      dz_78_q  <= dz_77_q;
      press_q  <= press_d;
      dz_q     <= dz_78_q;
    end
  end

  assign m_axis_tdata = {7'b0, press_q, side_q[NSt-1].centi, side_q[NSt-1].fine};
  assign m_axis_tuser = dz_q;

endmodule
`default_nettype wire

@@ hdl/btpc_checker.sv @@
// Checker: port-level properties of the compensation pipeline, bound to the top level.
`default_nettype none
module btpc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [btpc_pkg::InDataW-1:0]  s_axis_tdata,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [btpc_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic                          m_axis_tuser,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o,
  input wire logic [btpc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input wire logic [btpc_pkg::CoeffW-1:0]   cfg_data_i
);

  logic signed [34:0] centi_chk;
  logic unused_ok;

  assign centi_chk = $signed({{3{m_axis_tdata[31]}}, m_axis_tdata[31:0]}) * 35'sd5 + 35'sd128;
  assign unused_ok = s_axis_tvalid ^ (|s_axis_tdata) ^ cfg_valid_i ^ cfg_ready_o
                   ^ (|cfg_addr_i) ^ (|cfg_data_i);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input held off without an output stall");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[88:57] == 32'd0)
    else $error("zero divisor with non-zero pressure");

  a_centi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[56:32] == centi_chk[32:8])
    else $error("centidegrees do not match fine temperature");

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (.*);
`default_nettype wire
